FILE: hw/rtl/keypad_scan_auto_repeat_assert.svh
// ----------------------------------------------------------------------------
// Keypad scanner assertion macros
// Concurrent checks that can be compiled out by defining NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_AUTO_REPEAT_ASSERT_SVH
`define KEYPAD_SCAN_AUTO_REPEAT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, quiet during reset.
`define KPSAR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad scanner check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define KPSAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad scanner check failed");

`else

`define KPSAR_ASSERT_NOW(label, ante, cons)
`define KPSAR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/kpsar_pkg.sv
// ----------------------------------------------------------------------------
// kpsar_pkg
// Types and constants shared by the keypad scanner modules.
// ----------------------------------------------------------------------------
package kpsar_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RPT_INTERVAL   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] REFRESH_PERIOD_RST = 16'd10;
  localparam logic [CFG_DATA_W-1:0] REPEAT_DELAY_RST   = 16'd500;
  localparam logic [CFG_DATA_W-1:0] RPT_INTERVAL_RST   = 16'd100;

  typedef enum logic [2:0] {
    KEY_NONE   = 3'd0,
    KEY_UP     = 3'd1,
    KEY_DOWN   = 3'd2,
    KEY_RIGHT  = 3'd3,
    KEY_LEFT   = 3'd4,
    KEY_SELECT = 3'd5
  } key_t;

  typedef struct packed {
    logic up_pressed;
    logic right_pressed;
    logic select_pressed;
    logic left_pressed;
    logic down_pressed;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_key;
    logic [2:0] held_key;
  } out_item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] refresh_period;
    logic [CFG_DATA_W-1:0] repeat_delay;
    logic [CFG_DATA_W-1:0] rpt_interval;
  } cfg_t;

endpackage

FILE: hw/rtl/kpsar_core.sv
// ----------------------------------------------------------------------------
// kpsar_core
// Tick counters, key sampling and auto-repeat decision for one tick per cycle while step_en is high.
// ----------------------------------------------------------------------------
module kpsar_core #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  kpsar_pkg::in_item_t  keys,
  input  kpsar_pkg::cfg_t      cfg,
  output kpsar_pkg::out_item_t result
);
  import kpsar_pkg::*;

  localparam int unsigned CW = (TIMER_WIDTH > CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;
  localparam logic [TIMER_WIDTH-1:0] CNT_MAX = {TIMER_WIDTH{1'b1}};

  logic [TIMER_WIDTH-1:0] since_sample_r, since_sample_nxt;
  logic [TIMER_WIDTH-1:0] since_change_r, since_change_nxt;
  logic [TIMER_WIDTH-1:0] since_emit_r, since_emit_nxt;
  key_t                   cur_key_r, cur_key_nxt;

  logic [TIMER_WIDTH-1:0] sample_inc, change_inc, emit_inc;
  logic                   sample_fire;
  logic                   repeat_ok;
  key_t                   picked;
  key_t                   event_key;

  always_comb begin
    sample_inc = (since_sample_r == CNT_MAX) ? CNT_MAX : since_sample_r + TIMER_WIDTH'(1);
    change_inc = (since_change_r == CNT_MAX) ? CNT_MAX : since_change_r + TIMER_WIDTH'(1);
    emit_inc   = (since_emit_r   == CNT_MAX) ? CNT_MAX : since_emit_r + TIMER_WIDTH'(1);
  end

  // Fixed priority: up, right, select, left, down
  always_comb begin
    if (keys.up_pressed) begin
      picked = KEY_UP;
    end else if (keys.right_pressed) begin
      picked = KEY_RIGHT;
    end else if (keys.select_pressed) begin
      picked = KEY_SELECT;
    end else if (keys.left_pressed) begin
      picked = KEY_LEFT;
    end else if (keys.down_pressed) begin
      picked = KEY_DOWN;
    end else begin
      picked = KEY_NONE;
    end
  end

  assign sample_fire = CW'(sample_inc) > CW'(cfg.refresh_period);
  assign repeat_ok   = (CW'(change_inc) >= CW'(cfg.repeat_delay)) &&
                       (CW'(emit_inc) >= CW'(cfg.rpt_interval));

  always_comb begin
    since_sample_nxt = sample_inc;
    since_change_nxt = change_inc;
    since_emit_nxt   = emit_inc;
    cur_key_nxt      = cur_key_r;
    event_key        = KEY_NONE;
    if (sample_fire) begin
      since_sample_nxt = '0;
      if (picked != cur_key_r) begin
        cur_key_nxt      = picked;
        since_change_nxt = '0;
        since_emit_nxt   = '0;
        event_key        = picked;
      end else if (picked != KEY_NONE && repeat_ok) begin
        since_emit_nxt = '0;
        event_key      = picked;
      end
    end
  end

  assign result.event_key = event_key;
  assign result.held_key  = cur_key_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_sample_r <= '0;
      since_change_r <= '0;
      since_emit_r   <= '0;
      cur_key_r      <= KEY_NONE;
    end else if (step_en) begin
      since_sample_r <= since_sample_nxt;
      since_change_r <= since_change_nxt;
      since_emit_r   <= since_emit_nxt;
      cur_key_r      <= cur_key_nxt;
    end
  end

`include "keypad_scan_auto_repeat_assert.svh"

  // Emit timer restarts whenever the change timer does, so it never runs ahead
  `KPSAR_ASSERT_NOW(a_emit_not_ahead, 1'b1, since_emit_r <= since_change_r)
  // Held key stays a defined code
  `KPSAR_ASSERT_NOW(a_key_in_range, 1'b1, cur_key_r <= KEY_SELECT)
  // Any emitted key is the key held after the step
  `KPSAR_ASSERT_NOW(a_event_matches_key, event_key != KEY_NONE, event_key == cur_key_nxt)

endmodule

FILE: hw/rtl/keypad_scan_auto_repeat.sv
// Path: an accepted tick is held in the input register, then stepped into the result register,
// from which its result transfers on out_ once the sink takes it.
// Throughput: one tick per cycle while the sink takes results; a stalled result lets one
// more tick into the input register, then in_stall rises until the sink drains.
// Reset (rst_n low, synchronous): timers cleared, held key none, registers at
// refresh_period 10, repeat_delay 500, repeat interval 100, pipeline emptied.
// ----------------------------------------------------------------------------
// keypad_scan_auto_repeat
// Keypad scanner with auto-repeat: one result per millisecond tick.
// ----------------------------------------------------------------------------
module keypad_scan_auto_repeat #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tick channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  kpsar_pkg::in_item_t                  in_data,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output kpsar_pkg::out_item_t                 out_data,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [kpsar_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [kpsar_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import kpsar_pkg::*;

  cfg_t      cfg_r;

  // Input stage: registered tick waiting for the step logic
  logic      s1_valid_r;
  in_item_t  s1_data_r;

  // Result stage
  logic      out_valid_r;
  out_item_t out_data_r;

  logic      out_free;
  logic      s1_adv;
  logic      in_xfer;
  out_item_t step_result;
  logic      ev_shown;

  // The result register is free when empty or when its transfer happens now.
  assign out_free = !out_valid_r || !out_stall;
  // Advance the registered tick into the result register whenever room opens.
  assign s1_adv   = s1_valid_r && out_free;
  // Stall the source only when the input stage is full and cannot drain.
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  // Configuration registers; writes must arrive only while no tick is in flight (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.refresh_period <= REFRESH_PERIOD_RST;
      cfg_r.repeat_delay   <= REPEAT_DELAY_RST;
      cfg_r.rpt_interval   <= RPT_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_REFRESH_PERIOD: cfg_r.refresh_period <= cfg_wdata;
        CFG_REPEAT_DELAY:   cfg_r.repeat_delay   <= cfg_wdata;
        CFG_RPT_INTERVAL:   cfg_r.rpt_interval   <= cfg_wdata;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Input stage payload: capture on every transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
  end

  // Step the timers and key state once per tick as it moves to the result stage.
  kpsar_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .keys    (s1_data_r),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  // Result stage control: load on advance, clear after the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ev_shown = out_valid_r && (out_data_r.event_key != KEY_NONE);

`include "keypad_scan_auto_repeat_assert.svh"

  // A tick leaving the input stage always lands in the result register
  `KPSAR_ASSERT_NEXT(a_adv_lands, s1_adv, out_valid_r)
  // An emitted key is always the key held after that tick
  `KPSAR_ASSERT_NOW(a_event_is_held, ev_shown, out_data_r.event_key == out_data_r.held_key)
  // Held key code stays within the defined key set
  `KPSAR_ASSERT_NOW(a_held_in_range, out_valid_r, out_data_r.held_key <= KEY_SELECT)

endmodule
